[hw/rtl/dsh_pkg.sv]
// Shared types and constants of the diamond-square height map generator.
// No dependencies; used by every module of the block but dsh_grid_mem.
`timescale 1ns / 1ps

package dsh_pkg;

  localparam int GRID_SIZE_DEF   = 32;
  localparam int RANDOM_BITS_DEF = 16;

  localparam int RND_W     = 16;
  localparam int COORD_O_W = 5;
  localparam int HEIGHT_W  = 18;
  localparam int ACC_W     = HEIGHT_W + 2;
  localparam int FRAC_SH   = 17;
  localparam int LVL_W     = 3;
  localparam int SHAMT_W   = 4;
  localparam int ADD_SH_W  = 6;

  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;

  typedef enum logic [1:0] {
    PH_SQUARE = 2'd0,
    PH_DIAM_A = 2'd1,
    PH_DIAM_B = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    NB_FIRST  = 2'd0,
    NB_SECOND = 2'd1,
    NB_THIRD  = 2'd2,
    NB_FOURTH = 2'd3
  } nb_e;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_RD0   = 3'd2,
    ST_RD1   = 3'd3,
    ST_RD2   = 3'd4,
    ST_RD3   = 3'd5,
    ST_WR    = 3'd6
  } st_e;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             map_last;
  } walk_stat_t;

endpackage

[hw/rtl/diamond_square_heightmap_top.sv]
// Diamond-square height map generator, top level: sequencer, grid memory,
// visiting order and result register. Uses dsh_pkg, dsh_grid_mem, dsh_walker.
`timescale 1ns / 1ps

// Each accepted item (one random value) produces one height sample of a
// wrapping GRID_SIZE x GRID_SIZE map; a map is GRID_SIZE*GRID_SIZE-1 items and
// its last sample carries map_done, after which the next item starts a new map.
// Each item makes four neighbor reads and one write-back on the
// single-port grid memory. The next item is accepted in the cycle its
// predecessor writes; a result held in the output register stalls the
// write-back of the following item and with it the acceptance of the next.
// After reset every grid entry is cleared, with in_ready_o low. Between maps
// no clearing is needed: each entry carries a map epoch bit, and an entry
// from an older map reads as zero.
module diamond_square_heightmap_top #(
  parameter int GRID_SIZE   = dsh_pkg::GRID_SIZE_DEF,
  parameter int RANDOM_BITS = dsh_pkg::RANDOM_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [dsh_pkg::RND_W-1:0]       random_fraction_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dsh_pkg::COORD_O_W-1:0]   column_o,
  output logic [dsh_pkg::COORD_O_W-1:0]   row_o,
  output logic [dsh_pkg::HEIGHT_W-1:0]    height_o,
  output logic                            map_done_o
);

  localparam int CW = $clog2(GRID_SIZE);
  localparam int AW = 2 * CW;
  localparam int HW = dsh_pkg::HEIGHT_W;
  localparam int DW = HW + 1;
  localparam int RW = dsh_pkg::RND_W;
  localparam logic [RW-1:0] RND_MASK =
    RW'((64'd1 << RANDOM_BITS) - 64'd1);
  localparam logic [dsh_pkg::ADD_SH_W-1:0] RB_SH = dsh_pkg::ADD_SH_W'(RANDOM_BITS);

  dsh_pkg::st_e state_q, state_d;

  logic [AW-1:0]   clr_cnt_q, clr_cnt_d;
  logic            epoch_q, epoch_d;
  logic [RW-1:0]   rnd_q, rnd_d;
  logic [HW-1:0]   add_q, add_d;
  logic [dsh_pkg::ACC_W-1:0] acc_q, acc_d;

  logic                         out_valid_q, out_valid_d;
  logic [dsh_pkg::COORD_O_W-1:0] column_q, column_d, row_q, row_d;
  logic [HW-1:0]                height_q, height_d;
  logic                         map_done_q, map_done_d;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_addr;
  logic [DW-1:0]   mem_wdata, mem_rdata;
  logic [HW-1:0]   rd_h;

  dsh_pkg::nb_e        nb_sel;
  dsh_pkg::walk_stat_t stat;
  logic [CW-1:0]       tgt_x, tgt_y;
  logic [AW-1:0]       nb_addr;

  logic            commit, accept;
  logic [dsh_pkg::ACC_W-1:0] sum;
  logic [HW:0]     h_wide;
  logic [HW-1:0]   h_new;
  logic [RW+dsh_pkg::FRAC_SH-1:0] rnd_ext;
  logic [dsh_pkg::ADD_SH_W-1:0]   add_sh;
  logic [CW+dsh_pkg::COORD_O_W-1:0] x_ext, y_ext;

  dsh_grid_mem #(
    .AW (AW),
    .DW (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  dsh_walker #(
    .GRID_SIZE (GRID_SIZE)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (commit),
    .nb_sel_i  (nb_sel),
    .tgt_x_o   (tgt_x),
    .tgt_y_o   (tgt_y),
    .nb_addr_o (nb_addr),
    .stat_o    (stat)
  );

  assign commit = (state_q == dsh_pkg::ST_WR) && (!out_valid_q || out_ready_i);
  assign accept = in_valid_i && in_ready_o;

  assign rd_h = (mem_rdata[HW] == epoch_q) ? mem_rdata[HW-1:0] : '0;

  assign sum    = acc_q + dsh_pkg::ACC_W'(rd_h);
  assign h_wide = {1'b0, sum[dsh_pkg::ACC_W-1:2]} + {1'b0, add_q};
  assign h_new  = h_wide[HW] ? dsh_pkg::HEIGHT_MAX : h_wide[HW-1:0];

  assign rnd_ext = {rnd_q & RND_MASK, {dsh_pkg::FRAC_SH{1'b0}}};
  assign add_sh  = RB_SH + dsh_pkg::ADD_SH_W'(stat.level);

  assign x_ext = {{dsh_pkg::COORD_O_W{1'b0}}, tgt_x};
  assign y_ext = {{dsh_pkg::COORD_O_W{1'b0}}, tgt_y};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dsh_pkg::ST_CLEAR: if (clr_cnt_q == '1) state_d = dsh_pkg::ST_IDLE;
      dsh_pkg::ST_IDLE:  if (in_valid_i) state_d = dsh_pkg::ST_RD0;
      dsh_pkg::ST_RD0:   state_d = dsh_pkg::ST_RD1;
      dsh_pkg::ST_RD1:   state_d = dsh_pkg::ST_RD2;
      dsh_pkg::ST_RD2:   state_d = dsh_pkg::ST_RD3;
      dsh_pkg::ST_RD3:   state_d = dsh_pkg::ST_WR;
      dsh_pkg::ST_WR: begin
        if (commit) begin
          state_d = in_valid_i ? dsh_pkg::ST_RD0 : dsh_pkg::ST_IDLE;
        end
      end
      default: state_d = dsh_pkg::ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = nb_addr;
    mem_wdata  = {epoch_q, h_new};
    nb_sel     = dsh_pkg::NB_FIRST;
    unique case (state_q)
      dsh_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_q;
        mem_wdata = '0;
      end
      dsh_pkg::ST_IDLE: in_ready_o = 1'b1;
      dsh_pkg::ST_RD0: begin
        mem_re = 1'b1;
        nb_sel = dsh_pkg::NB_FIRST;
      end
      dsh_pkg::ST_RD1: begin
        mem_re = 1'b1;
        nb_sel = dsh_pkg::NB_SECOND;
      end
      dsh_pkg::ST_RD2: begin
        mem_re = 1'b1;
        nb_sel = dsh_pkg::NB_THIRD;
      end
      dsh_pkg::ST_RD3: begin
        mem_re = 1'b1;
        nb_sel = dsh_pkg::NB_FOURTH;
      end
      dsh_pkg::ST_WR: begin
        in_ready_o = commit;
        mem_we     = commit;
        mem_addr   = {tgt_y, tgt_x};
      end
      default: ;
    endcase
  end

  always_comb begin
    clr_cnt_d   = clr_cnt_q;
    epoch_d     = epoch_q;
    rnd_d       = rnd_q;
    add_d       = add_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    column_d    = column_q;
    row_d       = row_q;
    height_d    = height_q;
    map_done_d  = map_done_q;
    if (state_q == dsh_pkg::ST_CLEAR) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
    end
    if (accept) begin
      rnd_d = random_fraction_i;
    end
    if (state_q == dsh_pkg::ST_RD0) begin
      add_d = HW'(rnd_ext >> add_sh);
    end
    if (state_q == dsh_pkg::ST_RD1) begin
      acc_d = dsh_pkg::ACC_W'(rd_h);
    end else if (state_q == dsh_pkg::ST_RD2 || state_q == dsh_pkg::ST_RD3) begin
      acc_d = sum;
    end
    if (commit) begin
      out_valid_d = 1'b1;
      column_d    = x_ext[dsh_pkg::COORD_O_W-1:0];
      row_d       = y_ext[dsh_pkg::COORD_O_W-1:0];
      height_d    = h_new;
      map_done_d  = stat.map_last;
      if (stat.map_last) begin
        epoch_d = !epoch_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsh_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      epoch_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      epoch_q     <= epoch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q      <= rnd_d;
    add_q      <= add_d;
    acc_q      <= acc_d;
    column_q   <= column_d;
    row_q      <= row_d;
    height_q   <= height_d;
    map_done_q <= map_done_d;
  end

  assign out_valid_o = out_valid_q;
  assign column_o    = column_q;
  assign row_o       = row_q;
  assign height_o    = height_q;
  assign map_done_o  = map_done_q;

endmodule

[hw/rtl/dsh_grid_mem.sv]
// Single-port height grid memory with registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module dsh_grid_mem #(
  parameter int AW = 10,
  parameter int DW = 19
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/dsh_walker.sv]
// Visiting order of the diamond-square passes: level, phase and cell position,
// target point and wrapped neighbor addresses. Uses dsh_pkg.
`timescale 1ns / 1ps

module dsh_walker #(
  parameter  int GRID_SIZE = dsh_pkg::GRID_SIZE_DEF,
  localparam int CW        = $clog2(GRID_SIZE)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   advance_i,
  input  dsh_pkg::nb_e           nb_sel_i,
  output logic [CW-1:0]          tgt_x_o,
  output logic [CW-1:0]          tgt_y_o,
  output logic [2*CW-1:0]        nb_addr_o,
  output dsh_pkg::walk_stat_t    stat_o
);

  localparam int CCW = CW - 1;
  localparam logic [dsh_pkg::LVL_W-1:0] LAST_LEVEL = dsh_pkg::LVL_W'(CW - 1);
  localparam logic [CW-1:0] ONE = CW'(1);

  logic [dsh_pkg::LVL_W-1:0] level_q, level_d;
  dsh_pkg::phase_e           phase_q, phase_d;
  logic [CCW-1:0]            col_q, col_d, row_q, row_d;

  logic [dsh_pkg::SHAMT_W-1:0] step_sh, half_sh;
  logic [CW-1:0]  hs, bx, by, tx, ty, xm, xp, ym, yp, nx, ny;
  logic [CCW-1:0] cells_m1;
  logic           col_last, row_last, pass_end, map_last;

  assign step_sh  = dsh_pkg::SHAMT_W'(CW) - dsh_pkg::SHAMT_W'(level_q);
  assign half_sh  = step_sh - dsh_pkg::SHAMT_W'(1);
  assign hs       = ONE << half_sh;
  assign bx       = CW'(col_q) << step_sh;
  assign by       = CW'(row_q) << step_sh;
  assign cells_m1 = CCW'((32'd1 << level_q) - 32'd1);
  assign col_last = (col_q == cells_m1);
  assign row_last = (row_q == cells_m1);
  assign pass_end = col_last && row_last;
  assign map_last = (phase_q == dsh_pkg::PH_DIAM_B) && pass_end && (level_q == LAST_LEVEL);

  always_comb begin
    unique case (phase_q)
      dsh_pkg::PH_DIAM_A: begin
        tx = bx + hs;
        ty = by;
      end
      dsh_pkg::PH_DIAM_B: begin
        tx = bx;
        ty = by + hs;
      end
      default: begin
        tx = bx + hs;
        ty = by + hs;
      end
    endcase
  end

  assign xm = tx - hs;
  assign xp = tx + hs;
  assign ym = ty - hs;
  assign yp = ty + hs;

  always_comb begin
    if (phase_q == dsh_pkg::PH_SQUARE) begin
      unique case (nb_sel_i)
        dsh_pkg::NB_FIRST:  begin nx = xm; ny = ym; end
        dsh_pkg::NB_SECOND: begin nx = xp; ny = ym; end
        dsh_pkg::NB_THIRD:  begin nx = xm; ny = yp; end
        default:            begin nx = xp; ny = yp; end
      endcase
    end else begin
      unique case (nb_sel_i)
        dsh_pkg::NB_FIRST:  begin nx = xm; ny = ty; end
        dsh_pkg::NB_SECOND: begin nx = xp; ny = ty; end
        dsh_pkg::NB_THIRD:  begin nx = tx; ny = ym; end
        default:            begin nx = tx; ny = yp; end
      endcase
    end
  end

  always_comb begin
    level_d = level_q;
    phase_d = phase_q;
    col_d   = col_q;
    row_d   = row_q;
    if (phase_q == dsh_pkg::PH_DIAM_A) begin
      phase_d = dsh_pkg::PH_DIAM_B;
    end else begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + CCW'(1);
      end else begin
        col_d = col_q + CCW'(1);
      end
      if (phase_q == dsh_pkg::PH_DIAM_B) begin
        if (pass_end) begin
          phase_d = dsh_pkg::PH_SQUARE;
          level_d = level_q + dsh_pkg::LVL_W'(1);
        end else begin
          phase_d = dsh_pkg::PH_DIAM_A;
        end
      end else begin
        phase_d = pass_end ? dsh_pkg::PH_DIAM_A : dsh_pkg::PH_SQUARE;
      end
    end
    if (map_last) begin
      level_d = '0;
      phase_d = dsh_pkg::PH_SQUARE;
      col_d   = '0;
      row_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      phase_q <= dsh_pkg::PH_SQUARE;
      col_q   <= '0;
      row_q   <= '0;
    end else if (advance_i) begin
      level_q <= level_d;
      phase_q <= phase_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  assign tgt_x_o         = tx;
  assign tgt_y_o         = ty;
  assign nb_addr_o       = {ny, nx};
  assign stat_o.level    = level_q;
  assign stat_o.map_last = map_last;

endmodule

[hw/rtl/dsh_checker.sv]
// Port-level checks of the diamond-square height map generator, bound to
// the top level. Uses dsh_pkg for field widths.
`timescale 1ns / 1ps

module dsh_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [dsh_pkg::COORD_O_W-1:0] column_o,
  input logic [dsh_pkg::COORD_O_W-1:0] row_o,
  input logic [dsh_pkg::HEIGHT_W-1:0]  height_o,
  input logic                          map_done_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(column_o) && $stable(row_o)
      && $stable(height_o) && $stable(map_done_o))
    else $error("stalled result item changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o
      ##1 !in_ready_o)
    else $error("item accepted during the neighbor reads");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 6))
    else $error("result item without an item accepted six cycles before");

endmodule

bind diamond_square_heightmap_top dsh_checker u_dsh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .column_o    (column_o),
  .row_o       (row_o),
  .height_o    (height_o),
  .map_done_o  (map_done_o)
);

[verif/diamond_square_heightmap_top_test.sv]
// Self-checking bench for the diamond-square height map generator: random
// fractions in, each sample predicted in-bench and compared field by field.
// Depends on dsh_pkg and diamond_square_heightmap_top.
`timescale 1ns / 1ps

module diamond_square_heightmap_top_test;

  localparam int GRID     = dsh_pkg::GRID_SIZE_DEF;
  localparam int RBITS    = dsh_pkg::RANDOM_BITS_DEF;
  localparam int LIMIT    = 400000;
  localparam int N_RANDOM = 700;
  localparam int N_AFTER  = 40;

  localparam logic [dsh_pkg::RND_W-1:0] CORNER_FRACTIONS [25] = '{
    16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA,
    16'hFFFF, 16'h0000, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h3333,
    16'hCCCC, 16'hFFFE, 16'h0002, 16'h4000, 16'hBFFF, 16'hFFFF, 16'hFFFF,
    16'h0000, 16'h1234, 16'hEDCB, 16'h8001
  };

  typedef struct packed {
    logic [dsh_pkg::COORD_O_W-1:0] column;
    logic [dsh_pkg::COORD_O_W-1:0] row;
    logic [dsh_pkg::HEIGHT_W-1:0]  height;
    logic                          map_done;
  } sample_t;

  typedef enum logic [1:0] {
    DRAIN_FREE   = 2'd0,
    DRAIN_COIN   = 2'd1,
    DRAIN_SPARSE = 2'd2,
    DRAIN_RUNS   = 2'd3
  } drain_e;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [dsh_pkg::RND_W-1:0]     random_fraction_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [dsh_pkg::COORD_O_W-1:0] column_o;
  logic [dsh_pkg::COORD_O_W-1:0] row_o;
  logic [dsh_pkg::HEIGHT_W-1:0]  height_o;
  logic                          map_done_o;

  // predictor state
  logic [dsh_pkg::HEIGHT_W-1:0] height_map [GRID*GRID];
  int unsigned                  map_level;
  dsh_pkg::phase_e              map_phase;
  int unsigned                  cell_x;
  int unsigned                  cell_y;
  int unsigned                  maps_completed;

  sample_t     pending_samples [$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned burst_left;

  diamond_square_heightmap_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .random_fraction_i (random_fraction_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .column_o          (column_o),
    .row_o             (row_o),
    .height_o          (height_o),
    .map_done_o        (map_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void clear_map();
    foreach (height_map[i]) height_map[i] = '0;
    map_level = 0;
    map_phase = dsh_pkg::PH_SQUARE;
    cell_x    = 0;
    cell_y    = 0;
  endfunction

  function automatic logic [dsh_pkg::HEIGHT_W-1:0] height_at(input int unsigned x,
                                                             input int unsigned y);
    return height_map[(x % GRID) + (y % GRID) * GRID];
  endfunction

  // Computes the sample the block must emit for one accepted fraction and
  // advances the visiting order.
  function automatic void predict_sample(input logic [dsh_pkg::RND_W-1:0] rnd);
    int unsigned                    stride;
    int unsigned                    half;
    int unsigned                    cells;
    int unsigned                    px;
    int unsigned                    py;
    logic [dsh_pkg::HEIGHT_W+1:0]   nsum;
    logic [dsh_pkg::HEIGHT_W+1:0]   hnew;
    longint unsigned                bump;
    bit                             pass_end;
    bit                             last;
    sample_t                        s;
    stride = GRID >> (map_level & 7);
    half   = stride / 2;
    if (stride < 2) begin
      stride = 2;
      half   = 1;
    end
    cells = (GRID + stride - 1) / stride;
    case (map_phase)
      dsh_pkg::PH_DIAM_A: begin
        px = cell_x * stride + half;
        py = cell_y * stride;
      end
      dsh_pkg::PH_DIAM_B: begin
        px = cell_x * stride;
        py = cell_y * stride + half;
      end
      default: begin
        px = cell_x * stride + half;
        py = cell_y * stride + half;
      end
    endcase
    px = px % GRID + GRID;
    py = py % GRID + GRID;
    if (map_phase == dsh_pkg::PH_DIAM_A || map_phase == dsh_pkg::PH_DIAM_B)
      nsum = height_at(px - half, py) + height_at(px + half, py)
           + height_at(px, py - half) + height_at(px, py + half);
    else
      nsum = height_at(px - half, py - half) + height_at(px + half, py - half)
           + height_at(px - half, py + half) + height_at(px + half, py + half);
    bump = (longint'(rnd & ((1 << RBITS) - 1)) << dsh_pkg::FRAC_SH)
           >> (RBITS + (map_level & 7));
    hnew = (dsh_pkg::HEIGHT_W+2)'((nsum >> 2) + bump);
    if (hnew > dsh_pkg::HEIGHT_MAX) hnew = {2'b00, dsh_pkg::HEIGHT_MAX};
    height_map[(px % GRID) + (py % GRID) * GRID] = hnew[dsh_pkg::HEIGHT_W-1:0];

    last = 1'b0;
    if (map_phase == dsh_pkg::PH_DIAM_A) begin
      map_phase = dsh_pkg::PH_DIAM_B;
    end else begin
      pass_end = 1'b0;
      cell_x++;
      if (cell_x >= cells) begin
        cell_x = 0;
        cell_y++;
        if (cell_y >= cells) begin
          cell_y   = 0;
          pass_end = 1'b1;
        end
      end
      if (map_phase == dsh_pkg::PH_DIAM_B) begin
        map_phase = dsh_pkg::PH_DIAM_A;
        if (pass_end) begin
          map_phase = dsh_pkg::PH_SQUARE;
          map_level++;
          if ((GRID >> map_level) < 2 || map_level > 7) last = 1'b1;
        end
      end else begin
        map_phase = pass_end ? dsh_pkg::PH_DIAM_A : dsh_pkg::PH_SQUARE;
      end
    end

    s.column   = dsh_pkg::COORD_O_W'((px % GRID) & 31);
    s.row      = dsh_pkg::COORD_O_W'((py % GRID) & 31);
    s.height   = hnew[dsh_pkg::HEIGHT_W-1:0];
    s.map_done = last;
    pending_samples = {pending_samples, s};
    if (last) begin
      clear_map();
      maps_completed++;
    end
  endfunction

  // Sends one item; valid drops only between bursts.
  task automatic send_fraction(input logic [dsh_pkg::RND_W-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i        <= 1'b1;
    random_fraction_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    predict_sample(value);
  endtask

  function automatic logic [dsh_pkg::RND_W-1:0] pick_fraction();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return dsh_pkg::RND_W'(1) << $urandom_range(0, dsh_pkg::RND_W - 1);
      3:       return ~(dsh_pkg::RND_W'(1) << $urandom_range(0, dsh_pkg::RND_W - 1));
      default: return dsh_pkg::RND_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic test_directed_extremes();
    foreach (CORNER_FRACTIONS[i]) send_fraction(CORNER_FRACTIONS[i]);
  endtask

  task automatic test_random_fractions();
    repeat (N_RANDOM) send_fraction(pick_fraction());
  endtask

  // Finishes the current map, then checks that the next one starts clean.
  task automatic test_map_completion();
    int unsigned target;
    target = maps_completed + 1;
    while (maps_completed < target) send_fraction(pick_fraction());
    repeat (N_AFTER) send_fraction(pick_fraction());
  endtask

  initial begin : drain_pattern
    drain_e      mode;
    int unsigned left;
    mode        = DRAIN_FREE;
    left        = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = drain_e'($urandom_range(0, 3));
        left = $urandom_range(16, 160);
      end
      left--;
      case (mode)
        DRAIN_FREE:   out_ready_i <= 1'b1;
        DRAIN_COIN:   out_ready_i <= ($urandom_range(0, 1) == 1);
        DRAIN_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
        default:      out_ready_i <= ((left / 8) % 2 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : check_samples
    sample_t due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected item: column %0d row %0d height %0h", column_o, row_o, height_o);
        mismatches++;
      end else begin
        due = pending_samples.pop_front();
        if (column_o !== due.column) begin
          $error("column: expected %0d, got %0d", due.column, column_o);
          mismatches++;
        end
        if (row_o !== due.row) begin
          $error("row: expected %0d, got %0d", due.row, row_o);
          mismatches++;
        end
        if (height_o !== due.height) begin
          $error("height: expected %0h, got %0h", due.height, height_o);
          mismatches++;
        end
        if (map_done_o !== due.map_done) begin
          $error("map_done: expected %0b, got %0b", due.map_done, map_done_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    random_fraction_i = '0;
    mismatches        = 0;
    cycle_count       = 0;
    burst_left        = 0;
    maps_completed    = 0;
    clear_map();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_random_fractions();
    test_map_completion();
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
